// ----- src/triangle_face_normal_defines.svh -----
// assertion macros for the triangle face normal block
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define TFN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define TFN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tfn_pkg.sv -----
// shared widths, stage indexes and lane type of the triangle face normal block
`timescale 1ns / 1ps

package tfn_pkg;

  localparam int COORD_BITS = 16;
  localparam int IN_W       = ((9 * COORD_BITS + 7) / 8) * 8;
  localparam int NRM_W      = 16;
  localparam int OUT_W      = 3 * NRM_W;

  // edge, product, cross magnitude, square and sum widths
  localparam int EW   = COORD_BITS + 1;
  localparam int PW   = 2 * COORD_BITS + 2;
  localparam int NMW  = 2 * COORD_BITS + 1;
  localparam int SQW  = 2 * NMW;
  localparam int SUMW = SQW + 2;

  // root digits and the working width of the digit recurrence
  localparam int ROOT_BITS = 16;
  localparam int RBI_W     = $clog2(ROOT_BITS);
  localparam int SCALE_SH  = 2 * (ROOT_BITS - 1);
  localparam int WW        = SUMW + 2 * ROOT_BITS;

  // pipeline stage indexes
  localparam int ST_E  = 0;
  localparam int ST_P  = 1;
  localparam int ST_X  = 2;
  localparam int ST_Q  = 3;
  localparam int ST_S  = 4;
  localparam int ST_R0 = 5;
  localparam int ST_O  = ST_R0 + ROOT_BITS;
  localparam int NST   = ST_O + 1;

  typedef struct packed {
    logic [WW-1:0]        rem;
    logic [WW-1:0]        bms;
    logic [SUMW-1:0]      sum;
    logic [ROOT_BITS-1:0] m;
    logic                 neg;
    logic                 degen;
  } lane_t;

endpackage

// ----- src/tfn_root_step.sv -----
// one registered digit step of the length-normalizing root recurrence
`timescale 1ns / 1ps

module tfn_root_step (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tfn_pkg::RBI_W-1:0]  bit_idx,
  input  tfn_pkg::lane_t             d,
  output tfn_pkg::lane_t             q
);

  logic [tfn_pkg::RBI_W:0]  sh1;
  logic [tfn_pkg::RBI_W:0]  sh2;
  logic [tfn_pkg::WW-1:0]   trial;
  logic                     take;
  tfn_pkg::lane_t           q_nxt;

  assign sh1 = {1'b0, bit_idx} + {{tfn_pkg::RBI_W{1'b0}}, 1'b1};
  assign sh2 = {bit_idx, 1'b0};

  // cost of setting digit j: 2^(j+1)*m*S + 2^(2j)*S
  assign trial = (d.bms << sh1) + (tfn_pkg::WW'(d.sum) << sh2);
  assign take  = (trial <= d.rem);

  always_comb begin
    q_nxt = d;
    if (take) begin
      q_nxt.rem       = d.rem - trial;
      q_nxt.bms       = d.bms + (tfn_pkg::WW'(d.sum) << bit_idx);
      q_nxt.m[bit_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_nxt;
    end
  end

endmodule

// ----- src/triangle_face_normal.sv -----
// top level: triangle unit normal from three vertices, fully pipelined
//
//  channel | direction | tdata (low bit up)                        | tuser
//  in_     | slave     | v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z | -
//  out_    | master    | normal_x normal_y normal_z                 | degenerate
//
//  one triangle per cycle sustained while out_tready is held high
//  the pipeline is made of five arithmetic stages, sixteen root digit stages and the
//  output register
//  reset (rst_n, synchronous) clears only the stage valid bits
//  each stage loads when it is empty or its successor moves, so bubbles are
//  squeezed out and a stall loses or repeats nothing
`timescale 1ns / 1ps
`include "triangle_face_normal_defines.svh"

module triangle_face_normal (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  input  logic [tfn_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // normal_x, normal_y, normal_z
  output logic [tfn_pkg::OUT_W-1:0]   out_tdata,
  // degenerate
  output logic                        out_tuser
);

  localparam int C = tfn_pkg::COORD_BITS;

  // stage control: valid bits and load enables
  logic [tfn_pkg::NST-1:0] v_r;
  logic [tfn_pkg::NST-1:0] v_nxt;
  logic [tfn_pkg::NST:0]   en;

  assign en[tfn_pkg::NST] = out_tready;

  genvar gk;
  generate
    for (gk = 0; gk < tfn_pkg::NST; gk++) begin : g_en
      assign en[gk] = !v_r[gk] || en[gk+1];
    end
  endgenerate

  assign in_tready = en[0];

  always_comb begin
    for (int k = 0; k < tfn_pkg::NST; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k - 1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // edge stage: e1 = v1 - v0, e2 = v2 - v0
  logic signed [tfn_pkg::EW-1:0] e1_nxt [3];
  logic signed [tfn_pkg::EW-1:0] e2_nxt [3];
  logic signed [tfn_pkg::EW-1:0] e1_r   [3];
  logic signed [tfn_pkg::EW-1:0] e2_r   [3];

  generate
    for (gk = 0; gk < 3; gk++) begin : g_edge
      logic signed [C-1:0] c0;
      logic signed [C-1:0] c1;
      logic signed [C-1:0] c2;
      assign c0 = $signed(in_tdata[gk*C +: C]);
      assign c1 = $signed(in_tdata[(gk+3)*C +: C]);
      assign c2 = $signed(in_tdata[(gk+6)*C +: C]);
      assign e1_nxt[gk] = tfn_pkg::EW'(c1) - tfn_pkg::EW'(c0);
      assign e2_nxt[gk] = tfn_pkg::EW'(c2) - tfn_pkg::EW'(c0);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_E]) begin
      e1_r <= e1_nxt;
      e2_r <= e2_nxt;
    end
  end

  // product stage: the two cross terms of each component
  logic signed [tfn_pkg::PW-1:0] pa_nxt [3];
  logic signed [tfn_pkg::PW-1:0] pb_nxt [3];
  logic signed [tfn_pkg::PW-1:0] pa_r   [3];
  logic signed [tfn_pkg::PW-1:0] pb_r   [3];

  generate
    for (gk = 0; gk < 3; gk++) begin : g_prod
      localparam int IA = (gk + 1) % 3;
      localparam int IB = (gk + 2) % 3;
      assign pa_nxt[gk] = tfn_pkg::PW'(e1_r[IA]) * tfn_pkg::PW'(e2_r[IB]);
      assign pb_nxt[gk] = tfn_pkg::PW'(e1_r[IB]) * tfn_pkg::PW'(e2_r[IA]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_P]) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
  end

  // cross stage: exact components of e1 x e2
  logic signed [tfn_pkg::PW-1:0] n_nxt [3];
  logic signed [tfn_pkg::PW-1:0] n_r   [3];

  generate
    for (gk = 0; gk < 3; gk++) begin : g_cross
      assign n_nxt[gk] = pa_r[gk] - pb_r[gk];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_X]) begin
      n_r <= n_nxt;
    end
  end

  // square stage: sign, magnitude squared
  logic                   neg_nxt [3];
  logic [tfn_pkg::SQW-1:0] sq_nxt [3];
  logic                   neg_r   [3];
  logic [tfn_pkg::SQW-1:0] sq_r   [3];

  generate
    for (gk = 0; gk < 3; gk++) begin : g_sq
      logic signed [tfn_pkg::PW-1:0] abs_v;
      logic [tfn_pkg::NMW-1:0]       mag;
      assign neg_nxt[gk] = n_r[gk][tfn_pkg::PW-1];
      assign abs_v       = neg_nxt[gk] ? -n_r[gk] : n_r[gk];
      assign mag         = abs_v[tfn_pkg::NMW-1:0];
      assign sq_nxt[gk]  = tfn_pkg::SQW'(mag) * tfn_pkg::SQW'(mag);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_Q]) begin
      neg_r <= neg_nxt;
      sq_r  <= sq_nxt;
    end
  end

  // sum stage: squared length, and per lane the target 2^30 * n^2
  logic [tfn_pkg::SUMW-1:0] sum_nxt;
  tfn_pkg::lane_t           init_nxt [3];
  tfn_pkg::lane_t           init_r   [3];

  assign sum_nxt = tfn_pkg::SUMW'(sq_r[0]) + tfn_pkg::SUMW'(sq_r[1])
                 + tfn_pkg::SUMW'(sq_r[2]);

  generate
    for (gk = 0; gk < 3; gk++) begin : g_init
      always_comb begin
        init_nxt[gk].rem   = tfn_pkg::WW'(sq_r[gk]) << tfn_pkg::SCALE_SH;
        init_nxt[gk].bms   = '0;
        init_nxt[gk].sum   = sum_nxt;
        init_nxt[gk].m     = '0;
        init_nxt[gk].neg   = neg_r[gk];
        init_nxt[gk].degen = (sum_nxt == '0);
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_S]) begin
      init_r <= init_nxt;
    end
  end

  // root stages: m = largest value with m^2 * S <= 2^30 * n^2, one digit a stage
  tfn_pkg::lane_t root [3][tfn_pkg::ROOT_BITS+1];

  genvar gl;
  generate
    for (gl = 0; gl < 3; gl++) begin : g_lane
      assign root[gl][0] = init_r[gl];
      for (gk = 0; gk < tfn_pkg::ROOT_BITS; gk++) begin : g_step
        tfn_root_step u_step (
          .clk     (clk),
          .en      (en[tfn_pkg::ST_R0 + gk]),
          .bit_idx (tfn_pkg::RBI_W'(tfn_pkg::ROOT_BITS - 1 - gk)),
          .d       (root[gl][gk]),
          .q       (root[gl][gk+1])
        );
      end
    end
  endgenerate

  // output stage: q = (m + 1) / 2 rounds to nearest, ties away from zero
  logic [tfn_pkg::NRM_W-1:0] nrm_nxt [3];
  logic [tfn_pkg::NRM_W-1:0] nrm_r   [3];
  logic                      degen_r;

  generate
    for (gk = 0; gk < 3; gk++) begin : g_out
      logic [tfn_pkg::ROOT_BITS:0]  m_inc;
      logic [tfn_pkg::NRM_W-1:0]    qv;
      tfn_pkg::lane_t               fin;
      assign fin   = root[gk][tfn_pkg::ROOT_BITS];
      assign m_inc = {1'b0, fin.m} + {{tfn_pkg::ROOT_BITS{1'b0}}, 1'b1};
      assign qv    = tfn_pkg::NRM_W'(m_inc >> 1);
      assign nrm_nxt[gk] = fin.degen ? '0 : (fin.neg ? (~qv + 1'b1) : qv);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_O]) begin
      nrm_r   <= nrm_nxt;
      degen_r <= root[0][tfn_pkg::ROOT_BITS].degen;
    end
  end

  assign out_tvalid = v_r[tfn_pkg::ST_O];
  assign out_tdata  = {nrm_r[2], nrm_r[1], nrm_r[0]};
  assign out_tuser  = degen_r;

  // checks
  logic signed [tfn_pkg::NRM_W-1:0] chk_x;
  logic signed [tfn_pkg::NRM_W-1:0] chk_y;
  logic signed [tfn_pkg::NRM_W-1:0] chk_z;
  logic                             last_root_v;

  assign chk_x       = $signed(nrm_r[0]);
  assign chk_y       = $signed(nrm_r[1]);
  assign chk_z       = $signed(nrm_r[2]);
  assign last_root_v = v_r[tfn_pkg::ST_O - 1];

  `TFN_ASSERT_IMP(a_degen_zero, out_tvalid && out_tuser, out_tdata == '0,
    "degenerate result carries a nonzero normal")
  `TFN_ASSERT_IMP(a_empty_ready, !out_tvalid, in_tready,
    "pipeline with empty output register refuses input")
  `TFN_ASSERT_IMP(a_unit_range, out_tvalid,
    (chk_x <= 16'sd16384) && (chk_x >= -16'sd16384) &&
    (chk_y <= 16'sd16384) && (chk_y >= -16'sd16384) &&
    (chk_z <= 16'sd16384) && (chk_z >= -16'sd16384),
    "normal component beyond unit range")
  `TFN_ASSERT_NXT(a_drain, last_root_v && en[tfn_pkg::ST_O], out_tvalid,
    "item leaving the root stages was lost")

endmodule
